### rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// shared types and constants of the box frustum culling engine
// ----------------------------------------------------------------------------
package afc_pkg;

  // default field widths
  localparam int COORD_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 16;

  // configuration port geometry: four 64-bit rows at byte address 8*i
  localparam int REG_DATA_BITS = 64;
  localparam int REG_ADDR_BITS = 5;
  localparam int REG_SEL_LSB   = 3;
  localparam int ROW_COUNT     = 4;

  // register indexes
  typedef enum logic [1:0] {
    REG_ROW_ZERO  = 2'd0,
    REG_ROW_ONE   = 2'd1,
    REG_ROW_TWO   = 2'd2,
    REG_ROW_THREE = 2'd3
  } reg_index_t;

  // identity matrix in Q4.12
  localparam logic [REG_DATA_BITS-1:0] ROW_ZERO_RESET  = 64'h0000_0000_0000_1000;
  localparam logic [REG_DATA_BITS-1:0] ROW_ONE_RESET   = 64'h0000_0000_1000_0000;
  localparam logic [REG_DATA_BITS-1:0] ROW_TWO_RESET   = 64'h0000_1000_0000_0000;
  localparam logic [REG_DATA_BITS-1:0] ROW_THREE_RESET = 64'h1000_0000_0000_0000;

  // w = 1 in Q8.8 is a left shift by eight
  localparam int W_ONE_SHIFT = 8;

  // clip code bit positions
  localparam int CODE_BITS    = 6;
  localparam int PLANE_LEFT   = 0;
  localparam int PLANE_RIGHT  = 1;
  localparam int PLANE_BOTTOM = 2;
  localparam int PLANE_TOP    = 3;
  localparam int PLANE_FAR    = 4;
  localparam int PLANE_NEAR   = 5;
  localparam logic [CODE_BITS-1:0] CODE_ALL = '1;

  localparam int CORNER_COUNT = 8;
  localparam int AXIS_COUNT   = 3;

  typedef enum logic [1:0] {
    VERDICT_INSIDE  = 2'd0,
    VERDICT_OUTSIDE = 2'd1,
    VERDICT_PARTIAL = 2'd2
  } verdict_t;

endpackage

### rtl/afc_ifs.sv
// ----------------------------------------------------------------------------
// afc channel interfaces
// box request channel and cull result channel, valid/ready handshake
// ----------------------------------------------------------------------------

// box request: two opposite corners
interface afc_box_if #(
  parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] low_x;
  logic signed [COORD_BITS-1:0] low_y;
  logic signed [COORD_BITS-1:0] low_z;
  logic signed [COORD_BITS-1:0] high_x;
  logic signed [COORD_BITS-1:0] high_y;
  logic signed [COORD_BITS-1:0] high_z;

  modport source (output valid, low_x, low_y, low_z, high_x, high_y, high_z,
                  input ready);
  modport sink (input valid, low_x, low_y, low_z, high_x, high_y, high_z,
                output ready);
endinterface

// cull result
interface afc_cull_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [5:0] any_plane_mask;
  logic [5:0] all_plane_mask;

  modport source (output valid, verdict, any_plane_mask, all_plane_mask,
                  input ready);
  modport sink (input valid, verdict, any_plane_mask, all_plane_mask,
                output ready);
endinterface

### rtl/aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// clip outcode culling of an axis-aligned box against a view-projection matrix
// ----------------------------------------------------------------------------
// Accepts one box per clock while not stalled. The pipeline has four register
// stages: the per-axis products of both corner values with each matrix column
// (24 multipliers plus the w terms), the homogeneous sums of the eight corners,
// the six clip planes of each corner, and the AND/OR reduction into the result
// register. Each stage holds while the one after it is full and stalled, so
// bubbles close up under backpressure. Matrix rows are written over the APB
// port as 64-bit words at byte addresses 0, 8, 16 and 24; the user must change
// them only while the pipe is empty, as the block does not enforce it.
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  afc_box_if.sink                  box,
  afc_cull_if.source               cull,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [REG_ADDR_BITS-1:0] paddr,
  input  logic [REG_DATA_BITS-1:0] pwdata,
  output logic [REG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int PW      = COORD_BITS + COEF_BITS;   // exact product
  localparam int SW      = PW + 2;                   // sum of four terms
  localparam int CW      = SW + 1;                   // plane compare
  localparam int EXT_W   = 2 * REG_DATA_BITS;        // room for 4 * 32 bits
  localparam int SEL_W   = REG_ADDR_BITS - REG_SEL_LSB;

  // matrix registers
  logic [REG_DATA_BITS-1:0] row [ROW_COUNT];
  logic [SEL_W-1:0]         reg_sel;

  assign reg_sel = paddr[REG_ADDR_BITS-1:REG_SEL_LSB];
  assign pready  = 1'b1;
  assign prdata  = row[reg_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      row[REG_ROW_ZERO]  <= ROW_ZERO_RESET;
      row[REG_ROW_ONE]   <= ROW_ONE_RESET;
      row[REG_ROW_TWO]   <= ROW_TWO_RESET;
      row[REG_ROW_THREE] <= ROW_THREE_RESET;
    end else if (psel && penable && pwrite) begin
      row[reg_sel] <= pwdata;
    end
  end

  // coefficient unpacking, bits above bit 63 read as zero
  logic signed [COEF_BITS-1:0] coef [ROW_COUNT][ROW_COUNT];

  always_comb begin
    logic [EXT_W-1:0] ext;
    for (int r = 0; r < ROW_COUNT; r++) begin
      ext = EXT_W'(row[r]);
      for (int c = 0; c < ROW_COUNT; c++) begin
        coef[r][c] = signed'(ext[c*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  // stage handshake
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4      = !v4 || cull.ready;
  assign adv3      = !v3 || adv4;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign box.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= box.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // stage 1: products of each matrix column with both corner values
  logic signed [COORD_BITS-1:0] lo_in [AXIS_COUNT];
  logic signed [COORD_BITS-1:0] hi_in [AXIS_COUNT];
  logic signed [PW-1:0]         prod_lo [ROW_COUNT][AXIS_COUNT];
  logic signed [PW-1:0]         prod_hi [ROW_COUNT][AXIS_COUNT];
  logic signed [PW-1:0]         bias    [ROW_COUNT];

  assign lo_in[0] = box.low_x;
  assign lo_in[1] = box.low_y;
  assign lo_in[2] = box.low_z;
  assign hi_in[0] = box.high_x;
  assign hi_in[1] = box.high_y;
  assign hi_in[2] = box.high_z;

  always_ff @(posedge clk) begin
    if (adv1 && box.valid) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
          prod_lo[r][a] <= PW'(coef[r][a]) * PW'(lo_in[a]);
          prod_hi[r][a] <= PW'(coef[r][a]) * PW'(hi_in[a]);
        end
        bias[r] <= PW'(coef[r][AXIS_COUNT]) <<< W_ONE_SHIFT;
      end
    end
  end

  // stage 2: homogeneous coordinates of the eight corners
  logic signed [SW-1:0] hom [CORNER_COUNT][ROW_COUNT];

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      for (int k = 0; k < CORNER_COUNT; k++) begin
        for (int r = 0; r < ROW_COUNT; r++) begin
          hom[k][r] <= SW'(k[0] ? prod_hi[r][0] : prod_lo[r][0])
                     + SW'(k[1] ? prod_hi[r][1] : prod_lo[r][1])
                     + SW'(k[2] ? prod_hi[r][2] : prod_lo[r][2])
                     + SW'(bias[r]);
        end
      end
    end
  end

  // stage 3: clip code of each corner
  logic [CODE_BITS-1:0] code [CORNER_COUNT];

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      for (int k = 0; k < CORNER_COUNT; k++) begin
        code[k][PLANE_LEFT]   <= (CW'(hom[k][0]) + CW'(hom[k][3])) < 0;
        code[k][PLANE_RIGHT]  <= (CW'(hom[k][0]) - CW'(hom[k][3])) > 0;
        code[k][PLANE_BOTTOM] <= (CW'(hom[k][1]) + CW'(hom[k][3])) < 0;
        code[k][PLANE_TOP]    <= (CW'(hom[k][1]) - CW'(hom[k][3])) > 0;
        code[k][PLANE_FAR]    <= (CW'(hom[k][2]) - CW'(hom[k][3])) > 0;
        code[k][PLANE_NEAR]   <= hom[k][2][SW-1];
      end
    end
  end

  // stage 4: reduce codes and classify
  logic [CODE_BITS-1:0] any_next, all_next;
  verdict_t             verdict_next;
  verdict_t             verdict;
  logic [CODE_BITS-1:0] any_mask, all_mask;

  always_comb begin
    any_next = '0;
    all_next = CODE_ALL;
    for (int k = 0; k < CORNER_COUNT; k++) begin
      any_next = any_next | code[k];
      all_next = all_next & code[k];
    end
    if (any_next == '0) begin
      verdict_next = VERDICT_INSIDE;
    end else if (all_next != '0) begin
      verdict_next = VERDICT_OUTSIDE;
    end else begin
      verdict_next = VERDICT_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      verdict  <= verdict_next;
      any_mask <= any_next;
      all_mask <= all_next;
    end
  end

  assign cull.valid          = v4;
  assign cull.verdict        = verdict;
  assign cull.any_plane_mask = any_mask;
  assign cull.all_plane_mask = all_mask;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for aabb_frustum_cull
// drives box requests through the valid/ready channel with random gaps and
// result stalls, reprograms the matrix rows over apb between phases, and
// checks every cull result field by field against a table for typed directed
// boxes, otherwise an exact integer transform of the eight box corners
// ----------------------------------------------------------------------------
module testbench;
  import afc_pkg::*;

  // run shape
  localparam int PHASE_COUNT     = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PIPE_SLACK      = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIRECTED_COUNT  = 21;

  localparam logic [COORD_BITS_DEF-1:0] COORD_MIN = 16'h8000;
  localparam logic [COORD_BITS_DEF-1:0] COORD_MAX = 16'h7FFF;
  localparam logic [COEF_BITS_DEF-1:0]  COEF_MIN  = 16'h8000;
  localparam logic [COEF_BITS_DEF-1:0]  COEF_MAX  = 16'h7FFF;
  localparam logic [COEF_BITS_DEF-1:0]  COEF_ONE  = 16'h1000;

  // single-plane masks
  localparam logic [CODE_BITS-1:0] NO_HIT     = '0;
  localparam logic [CODE_BITS-1:0] HIT_LEFT   = CODE_BITS'(1 << PLANE_LEFT);
  localparam logic [CODE_BITS-1:0] HIT_RIGHT  = CODE_BITS'(1 << PLANE_RIGHT);
  localparam logic [CODE_BITS-1:0] HIT_BOTTOM = CODE_BITS'(1 << PLANE_BOTTOM);
  localparam logic [CODE_BITS-1:0] HIT_TOP    = CODE_BITS'(1 << PLANE_TOP);
  localparam logic [CODE_BITS-1:0] HIT_FAR    = CODE_BITS'(1 << PLANE_FAR);
  localparam logic [CODE_BITS-1:0] HIT_NEAR   = CODE_BITS'(1 << PLANE_NEAR);

  typedef enum int {
    MX_NEAR_IDENTITY,
    MX_PERSPECTIVE,
    MX_ZERO,
    MX_MAX,
    MX_MIN,
    MX_ONES,
    MX_RANDOM
  } matrix_kind_t;

  typedef struct packed {
    logic [COORD_BITS_DEF-1:0] low_x;
    logic [COORD_BITS_DEF-1:0] low_y;
    logic [COORD_BITS_DEF-1:0] low_z;
    logic [COORD_BITS_DEF-1:0] high_x;
    logic [COORD_BITS_DEF-1:0] high_y;
    logic [COORD_BITS_DEF-1:0] high_z;
  } box_t;

  typedef struct packed {
    verdict_t             verdict;
    logic [CODE_BITS-1:0] any_mask;
    logic [CODE_BITS-1:0] all_mask;
  } cull_result_t;

  typedef struct packed {
    box_t         box;
    logic         typed;
    cull_result_t want;
  } directed_row_t;

  // directed boxes under the reset identity matrix
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // zero point and a box well inside
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{VERDICT_INSIDE, NO_HIT, NO_HIT}},
    '{'{-16'sd128, -16'sd128, 16'sd64, 16'sd128, 16'sd128, 16'sd192}, 1'b1,
      '{VERDICT_INSIDE, NO_HIT, NO_HIT}},
    // corners exactly on every plane stay inside
    '{'{-16'sd256, -16'sd256, 16'sd0, 16'sd256, 16'sd256, 16'sd256}, 1'b1,
      '{VERDICT_INSIDE, NO_HIT, NO_HIT}},
    // one step past each plane
    '{'{16'sd257, 16'sd0, 16'sd0, 16'sd257, 16'sd0, 16'sd0}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_RIGHT, HIT_RIGHT}},
    '{'{-16'sd257, 16'sd0, 16'sd0, -16'sd257, 16'sd0, 16'sd0}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_LEFT, HIT_LEFT}},
    '{'{16'sd0, 16'sd257, 16'sd0, 16'sd0, 16'sd257, 16'sd0}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_TOP, HIT_TOP}},
    '{'{16'sd0, -16'sd257, 16'sd0, 16'sd0, -16'sd257, 16'sd0}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_BOTTOM, HIT_BOTTOM}},
    '{'{16'sd0, 16'sd0, 16'sd257, 16'sd0, 16'sd0, 16'sd257}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_FAR, HIT_FAR}},
    '{'{16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, -16'sd1}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_NEAR, HIT_NEAR}},
    // full coordinate range
    '{'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX}, 1'b1,
      '{VERDICT_PARTIAL, CODE_ALL, NO_HIT}},
    '{'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_LEFT | HIT_BOTTOM | HIT_NEAR, HIT_LEFT | HIT_BOTTOM | HIT_NEAR}},
    '{'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_RIGHT | HIT_TOP | HIT_FAR, HIT_RIGHT | HIT_TOP | HIT_FAR}},
    // swapped corners give the same corner set
    '{'{16'sd128, 16'sd128, 16'sd192, -16'sd128, -16'sd128, 16'sd64}, 1'b1,
      '{VERDICT_INSIDE, NO_HIT, NO_HIT}},
    '{'{16'sd1024, 16'sd128, 16'sd128, 16'sd512, 16'sd0, 16'sd0}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_RIGHT, HIT_RIGHT}},
    // straddling boxes
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0}, 1'b1,
      '{VERDICT_PARTIAL, HIT_RIGHT, NO_HIT}},
    '{'{16'sd0, 16'sd0, -16'sd128, 16'sd0, 16'sd0, 16'sd128}, 1'b1,
      '{VERDICT_PARTIAL, HIT_NEAR, NO_HIT}},
    '{'{-16'sd512, 16'sd0, 16'sd128, 16'sd512, 16'sd0, 16'sd128}, 1'b1,
      '{VERDICT_PARTIAL, HIT_LEFT | HIT_RIGHT, NO_HIT}},
    // all-ones point, only the near plane is hit
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1,
      '{VERDICT_OUTSIDE, HIT_NEAR, HIT_NEAR}},
    // odd bit patterns, left to the predictor
    '{'{16'h5555, 16'hAAAA, 16'sd300, -16'sd300, 16'sd77, -16'sd5}, 1'b0,
      '{VERDICT_INSIDE, NO_HIT, NO_HIT}},
    '{'{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6}, 1'b0,
      '{VERDICT_INSIDE, NO_HIT, NO_HIT}},
    '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0,
      '{VERDICT_INSIDE, NO_HIT, NO_HIT}}
  };

  localparam matrix_kind_t PHASE_PLAN [PHASE_COUNT] = '{
    MX_NEAR_IDENTITY, MX_ZERO, MX_PERSPECTIVE, MX_MAX, MX_RANDOM,
    MX_MIN, MX_NEAR_IDENTITY, MX_ONES, MX_RANDOM, MX_PERSPECTIVE
  };

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [REG_ADDR_BITS-1:0] paddr;
  logic [REG_DATA_BITS-1:0] pwdata;
  logic [REG_DATA_BITS-1:0] prdata;
  logic                     pready;

  afc_box_if  box_ch ();
  afc_cull_if cull_ch ();

  aabb_frustum_cull dut (
    .clk     (clk),
    .rst     (rst),
    .box     (box_ch),
    .cull    (cull_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the matrix rows as last written
  logic [REG_DATA_BITS-1:0] matrix_rows [ROW_COUNT] = '{
    ROW_ZERO_RESET, ROW_ONE_RESET, ROW_TWO_RESET, ROW_THREE_RESET
  };

  cull_result_t verdicts_due [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           quiet_tail = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // exact transform of the eight corners, clip codes, and reduction
  function automatic cull_result_t cull_verdict_of(input box_t b);
    logic signed [63:0] coef [ROW_COUNT][ROW_COUNT];
    logic signed [63:0] pt [AXIS_COUNT];
    logic signed [63:0] acc [ROW_COUNT];
    logic [CODE_BITS-1:0] code;
    logic [CODE_BITS-1:0] any_m;
    logic [CODE_BITS-1:0] all_m;
    cull_result_t res;
    any_m = '0;
    all_m = CODE_ALL;
    for (int r = 0; r < ROW_COUNT; r++)
      for (int c = 0; c < ROW_COUNT; c++)
        coef[r][c] = $signed(matrix_rows[r][c*COEF_BITS_DEF +: COEF_BITS_DEF]);
    for (int k = 0; k < CORNER_COUNT; k++) begin
      pt[0] = $signed(k[0] ? b.high_x : b.low_x);
      pt[1] = $signed(k[1] ? b.high_y : b.low_y);
      pt[2] = $signed(k[2] ? b.high_z : b.low_z);
      for (int r = 0; r < ROW_COUNT; r++) begin
        // w = 1 is the coordinate 256
        acc[r] = coef[r][3] <<< W_ONE_SHIFT;
        for (int c = 0; c < AXIS_COUNT; c++)
          acc[r] = acc[r] + coef[r][c] * pt[c];
      end
      code = '0;
      code[PLANE_LEFT]   = (acc[0] + acc[3]) < 64'sd0;
      code[PLANE_RIGHT]  = (acc[0] - acc[3]) > 64'sd0;
      code[PLANE_BOTTOM] = (acc[1] + acc[3]) < 64'sd0;
      code[PLANE_TOP]    = (acc[1] - acc[3]) > 64'sd0;
      code[PLANE_FAR]    = (acc[2] - acc[3]) > 64'sd0;
      code[PLANE_NEAR]   = acc[2] < 64'sd0;
      any_m = any_m | code;
      all_m = all_m & code;
    end
    if (any_m == '0)
      res.verdict = VERDICT_INSIDE;
    else if (all_m != '0)
      res.verdict = VERDICT_OUTSIDE;
    else
      res.verdict = VERDICT_PARTIAL;
    res.any_mask = any_m;
    res.all_mask = all_m;
    return res;
  endfunction

  // mostly boxes near the view volume, some fully random
  function automatic box_t next_box();
    int lo [AXIS_COUNT];
    int hi [AXIS_COUNT];
    int mid;
    int half;
    int tmp;
    box_t b;
    if ($urandom_range(0, 7) == 0) begin
      b = {$urandom, $urandom, $urandom};
    end else begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        mid = int'($urandom_range(0, 768)) - ((a == 2) ? 128 : 384);
        half = $urandom_range(0, 320);
        lo[a] = mid - half;
        hi[a] = mid + half;
        // occasional flat or swapped axis
        if ($urandom_range(0, 15) == 0)
          hi[a] = lo[a];
        if ($urandom_range(0, 7) == 0) begin
          tmp = lo[a];
          lo[a] = hi[a];
          hi[a] = tmp;
        end
      end
      b.low_x  = COORD_BITS_DEF'(lo[0]);
      b.low_y  = COORD_BITS_DEF'(lo[1]);
      b.low_z  = COORD_BITS_DEF'(lo[2]);
      b.high_x = COORD_BITS_DEF'(hi[0]);
      b.high_y = COORD_BITS_DEF'(hi[1]);
      b.high_z = COORD_BITS_DEF'(hi[2]);
    end
    return b;
  endfunction

  // one matrix row for a phase setting
  function automatic logic [REG_DATA_BITS-1:0] matrix_row_for(input matrix_kind_t kind,
                                                              input int r);
    logic [COEF_BITS_DEF-1:0] cf [ROW_COUNT];
    int unsigned gain;
    gain = $urandom_range(2048, 8192);
    for (int c = 0; c < ROW_COUNT; c++)
      cf[c] = '0;
    case (kind)
      MX_NEAR_IDENTITY: begin
        for (int c = 0; c < ROW_COUNT; c++)
          cf[c] = (c == r) ? COEF_BITS_DEF'(gain)
                           : COEF_BITS_DEF'(int'($urandom_range(0, 512)) - 256);
      end
      MX_PERSPECTIVE: begin
        if (r < 2) begin
          cf[r] = COEF_BITS_DEF'(gain);
        end else if (r == 2) begin
          cf[2] = COEF_BITS_DEF'(gain);
          cf[3] = COEF_BITS_DEF'(-int'($urandom_range(0, 2048)));
        end else begin
          // w takes z
          cf[2] = COEF_ONE;
        end
      end
      MX_ZERO: ;
      MX_MAX: for (int c = 0; c < ROW_COUNT; c++) cf[c] = COEF_MAX;
      MX_MIN: for (int c = 0; c < ROW_COUNT; c++) cf[c] = COEF_MIN;
      MX_ONES: for (int c = 0; c < ROW_COUNT; c++) cf[c] = '1;
      MX_RANDOM: for (int c = 0; c < ROW_COUNT; c++) cf[c] = COEF_BITS_DEF'($urandom);
    endcase
    return {cf[3], cf[2], cf[1], cf[0]};
  endfunction

  // apb write: setup, access, then back to idle
  task automatic write_row(input reg_index_t idx, input logic [REG_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_BITS'(int'(idx) << REG_SEL_LSB);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    matrix_rows[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one box request and record its expected verdict
  task automatic push_box(input box_t b, input logic typed, input cull_result_t want);
    int unsigned gap;
    gap = (quiet_tail || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 16);
    if (gap != 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    box_ch.valid  <= 1'b1;
    box_ch.low_x  <= b.low_x;
    box_ch.low_y  <= b.low_y;
    box_ch.low_z  <= b.low_z;
    box_ch.high_x <= b.high_x;
    box_ch.high_y <= b.high_y;
    box_ch.high_z <= b.high_z;
    do @(posedge clk); while (!box_ch.ready);
    verdicts_due.push_back(typed ? want : cull_verdict_of(b));
  endtask

  // wait for the pipe to empty
  task automatic settle();
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // main sequence
  initial begin : stimulus
    cull_result_t unused;
    unused = '{VERDICT_INSIDE, NO_HIT, NO_HIT};
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    box_ch.valid  <= 1'b0;
    box_ch.low_x  <= '0;
    box_ch.low_y  <= '0;
    box_ch.low_z  <= '0;
    box_ch.high_x <= '0;
    box_ch.high_y <= '0;
    box_ch.high_z <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      push_box(DIRECTED_ROWS[i].box, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      box_ch.valid <= 1'b0;
      settle();
      if (p == PHASE_COUNT - 1)
        quiet_tail = 1'b1;
      for (int r = 0; r < ROW_COUNT; r++)
        write_row(reg_index_t'(r), matrix_row_for(PHASE_PLAN[p], r));
      repeat (ITEMS_PER_PHASE)
        push_box(next_box(), 1'b0, unused);
    end

    box_ch.valid <= 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side stalls in random bursts
  initial begin : result_sink
    int unsigned run_len;
    int unsigned hold_len;
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 24);
      cull_ch.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (!quiet_tail) begin
        hold_len = $urandom_range(1, 16);
        cull_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    cull_result_t want;
    if (!rst && cull_ch.valid && cull_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result verdict %0d any_plane_mask %0h all_plane_mask %0h",
               cull_ch.verdict, cull_ch.any_plane_mask, cull_ch.all_plane_mask);
        mismatch_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (cull_ch.verdict !== want.verdict) begin
          $error("verdict expected %0d actual %0d", want.verdict, cull_ch.verdict);
          mismatch_count++;
        end
        if (cull_ch.any_plane_mask !== want.any_mask) begin
          $error("any_plane_mask expected %0h actual %0h", want.any_mask,
                 cull_ch.any_plane_mask);
          mismatch_count++;
        end
        if (cull_ch.all_plane_mask !== want.all_mask) begin
          $error("all_plane_mask expected %0h actual %0h", want.all_mask,
                 cull_ch.all_plane_mask);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
